// ===== rtl/ssfs_pkg.sv =====
package ssfs_pkg;

	// Field widths fixed by the register map and item formats.
	localparam int unsigned FRAME_W  = 12;
	localparam int unsigned SIDE_W   = 7;
	localparam int unsigned DELTA_W  = 20;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned ACC_W    = 40;
	localparam int unsigned PROD_W   = DELTA_W + GAIN_W;
	localparam int unsigned TOTAL_W  = FRAME_W + 1;
	localparam int unsigned HITS_W   = 7;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 20;

	// The frame count is capped at one full 12-bit index range.
	localparam logic [TOTAL_W-1:0] FRAME_LIMIT = 13'd4096;
	localparam logic [HITS_W-1:0]  HITS_MAX    = 7'd127;

	// Item actions.
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_PLAY  = 2'd1,
		ACT_PAUSE = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAMES_ACROSS   = 3'd0,
		REG_FRAMES_DOWN     = 3'd1,
		REG_FRAME_PERIOD    = 3'd2,
		REG_SPEED_GAIN      = 3'd3,
		REG_LOOP_ENABLE     = 3'd4,
		REG_CALLBACK_FRAME  = 3'd5,
		REG_CALLBACK_REPEAT = 3'd6,
		REG_USE_UNSCALED    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [DELTA_W-1:0] scaled_delta;
		logic [DELTA_W-1:0] unscaled_delta;
	} in_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_index;
		logic [POS_W-1:0]   frame_column;
		logic [POS_W-1:0]   frame_row;
		logic               is_playing;
		logic [HITS_W-1:0]  callback_hits;
		logic               active;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// Current register contents, handed from the register file to the sequencer.
	typedef struct packed {
		logic [SIDE_W-1:0]  frames_across;
		logic [SIDE_W-1:0]  frames_down;
		logic [DELTA_W-1:0] frame_period;
		logic [GAIN_W-1:0]  speed_gain;
		logic               loop_enable;
		logic [FRAME_W-1:0] callback_frame;
		logic               callback_repeat;
		logic               use_unscaled;
	} cfg_t;

	// Shared subtractor request and response.
	typedef struct packed {
		logic [ACC_W-1:0] a;
		logic [ACC_W-1:0] b;
	} sub_req_t;

	typedef struct packed {
		logic [ACC_W-1:0] diff;
		logic             ge;
	} sub_rsp_t;

endpackage

// ===== rtl/ssfs_chan_if.sv =====
interface ssfs_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ssfs_cfg_regs.sv =====
module ssfs_cfg_regs
	import ssfs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_valid,
	input  cfg_wr_t wr,
	output logic    wr_ready,
	output cfg_t    cfg
);

	cfg_t cfg_q;

	// Writes are always taken.
	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register file with its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frames_across   <= 7'd1;
			cfg_q.frames_down     <= 7'd1;
			cfg_q.frame_period    <= 20'd16667;
			cfg_q.speed_gain      <= 16'd256;
			cfg_q.loop_enable     <= 1'b1;
			cfg_q.callback_frame  <= '0;
			cfg_q.callback_repeat <= 1'b0;
			cfg_q.use_unscaled    <= 1'b0;
		end else if (wr_valid) begin
			case (cfg_reg_t'(wr.index))
				REG_FRAMES_ACROSS:   cfg_q.frames_across   <= wr.data[SIDE_W-1:0];
				REG_FRAMES_DOWN:     cfg_q.frames_down     <= wr.data[SIDE_W-1:0];
				REG_FRAME_PERIOD:    cfg_q.frame_period    <= wr.data[DELTA_W-1:0];
				REG_SPEED_GAIN:      cfg_q.speed_gain      <= wr.data[GAIN_W-1:0];
				REG_LOOP_ENABLE:     cfg_q.loop_enable     <= wr.data[0];
				REG_CALLBACK_FRAME:  cfg_q.callback_frame  <= wr.data[FRAME_W-1:0];
				REG_CALLBACK_REPEAT: cfg_q.callback_repeat <= wr.data[0];
				REG_USE_UNSCALED:    cfg_q.use_unscaled    <= wr.data[0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/ssfs_sub_unit.sv =====
module ssfs_sub_unit
	import ssfs_pkg::*;
(
	input  sub_req_t req,
	output sub_rsp_t rsp
);

	logic [ACC_W:0] diff_full;

	// One wide subtract; the borrow out gives the compare.
	assign diff_full = {1'b0, req.a} - {1'b0, req.b};
	assign rsp.diff  = diff_full[ACC_W-1:0];
	assign rsp.ge    = ~diff_full[ACC_W];

endmodule

// ===== rtl/ssfs_seq.sv =====
module ssfs_seq
	import ssfs_pkg::*;
#(
	parameter int MAX_SIDE  = 64,
	parameter int MAX_STEPS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      item_valid,
	input  in_item_t  item,
	output logic      item_ready,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res,
	output sub_req_t  sub_req,
	input  sub_rsp_t  sub_rsp
);

	localparam int unsigned STEP_W = $clog2(MAX_STEPS + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MUL   = 7'b0000010,
		S_ADD   = 7'b0000100,
		S_LOOP  = 7'b0001000,
		S_DINIT = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [DELTA_W-1:0]  dt_q;
	logic [PROD_W-1:0]   prod_q;
	logic [ACC_W-1:0]    acc_q;
	logic [FRAME_W-1:0]  frame_q;
	logic                playing_q;
	logic                cb_done_q;
	logic [HITS_W-1:0]   hits_q;
	logic [STEP_W-1:0]   steps_q;
	logic                active_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [SIDE_W-1:0]   across_q;
	logic [SIDE_W-1:0]   rem_q;
	logic [FRAME_W-1:0]  quo_q;
	logic [3:0]          bit_cnt_q;
	logic                res_valid_q;
	out_item_t           res_q;

	logic [SIDE_W-1:0]   across;
	logic [SIDE_W-1:0]   down;
	logic                active;
	logic [2*SIDE_W-1:0] area;
	logic [TOTAL_W-1:0]  total;
	logic [ACC_W-1:0]    period;
	logic [SIDE_W:0]     div_part;
	logic [ACC_W:0]      sum;
	logic                step_go;
	logic                at_last;
	logic [FRAME_W-1:0]  frame_next;
	logic                hit;

	// Sheet size, clamped per side and capped in total.
	assign across = (32'(cfg.frames_across) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : cfg.frames_across;
	assign down   = (32'(cfg.frames_down) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : cfg.frames_down;
	assign active = (across != '0) && (down != '0);
	assign area   = (2*SIDE_W)'(across) * (2*SIDE_W)'(down);
	assign total  = ((2*SIDE_W)'(FRAME_LIMIT) < area) ? FRAME_LIMIT : area[TOTAL_W-1:0];

	// Frame period in Q32.8 units.
	assign period = {{(ACC_W-DELTA_W-8){1'b0}}, cfg.frame_period, 8'd0};

	// Partial remainder for one restoring divide step.
	assign div_part = {rem_q, quo_q[FRAME_W-1]};

	// The shared subtractor serves the frame loop and the column/row divide.
	always_comb begin
		if (state_q == S_DIV) begin
			sub_req.a = ACC_W'(div_part);
			sub_req.b = ACC_W'(across_q);
		end else begin
			sub_req.a = acc_q;
			sub_req.b = period;
		end
	end

	// Saturating accumulate of the scaled time.
	assign sum = {1'b0, acc_q} + (ACC_W+1)'(prod_q);

	// One frame step of the loop.
	assign step_go    = playing_q && sub_rsp.ge && (steps_q < STEP_W'(MAX_STEPS));
	assign at_last    = {1'b0, frame_q} >= (total_q - TOTAL_W'(1));
	assign frame_next = at_last ? '0 : frame_q + FRAME_W'(1);
	assign hit        = (frame_next == cfg.callback_frame) && (!cb_done_q || cfg.callback_repeat);

	assign item_ready = (state_q == S_IDLE);
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dt_q        <= '0;
			prod_q      <= '0;
			acc_q       <= '0;
			frame_q     <= '0;
			playing_q   <= 1'b0;
			cb_done_q   <= 1'b0;
			hits_q      <= '0;
			steps_q     <= '0;
			active_q    <= 1'b0;
			total_q     <= '0;
			across_q    <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			bit_cnt_q   <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// The output state reloads the register itself when it frees.
			if (res_valid_q && res_ready && (state_q != S_OUT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						dt_q     <= cfg.use_unscaled ? item.unscaled_delta : item.scaled_delta;
						active_q <= active;
						total_q  <= total;
						across_q <= across;
						hits_q   <= '0;
						steps_q  <= '0;
						case (action_t'(item.action))
							ACT_PLAY: begin
								playing_q <= 1'b1;
								state_q   <= S_DINIT;
							end
							ACT_PAUSE: begin
								playing_q <= 1'b0;
								state_q   <= S_DINIT;
							end
							ACT_TICK: begin
								state_q <= active ? S_MUL : S_DINIT;
							end
							default: begin
								state_q <= S_DINIT;
							end
						endcase
					end
				end
				S_MUL: begin
					prod_q  <= PROD_W'(dt_q) * PROD_W'(cfg.speed_gain);
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (playing_q) begin
						acc_q <= sum[ACC_W] ? '1 : sum[ACC_W-1:0];
					end
					state_q <= S_LOOP;
				end
				S_LOOP: begin
					if (step_go) begin
						steps_q <= steps_q + STEP_W'(1);
						if (at_last && !cfg.loop_enable) begin
							// Stop on the last frame; no callback test here.
							frame_q   <= total_q[FRAME_W-1:0] - FRAME_W'(1);
							acc_q     <= '0;
							playing_q <= 1'b0;
							state_q   <= S_DINIT;
						end else begin
							frame_q <= frame_next;
							acc_q   <= sub_rsp.diff;
							if (hit) begin
								cb_done_q <= 1'b1;
								if (hits_q != HITS_MAX) begin
									hits_q <= hits_q + HITS_W'(1);
								end
							end
						end
					end else begin
						state_q <= S_DINIT;
					end
				end
				S_DINIT: begin
					rem_q     <= '0;
					quo_q     <= frame_q;
					bit_cnt_q <= 4'(FRAME_W - 1);
					state_q   <= S_DIV;
				end
				S_DIV: begin
					// One quotient bit per cycle.
					rem_q <= sub_rsp.ge ? sub_rsp.diff[SIDE_W-1:0] : div_part[SIDE_W-1:0];
					quo_q <= {quo_q[FRAME_W-2:0], sub_rsp.ge};
					if (bit_cnt_q == '0) begin
						state_q <= S_OUT;
					end else begin
						bit_cnt_q <= bit_cnt_q - 4'd1;
					end
				end
				S_OUT: begin
					if (!res_valid_q || res_ready) begin
						res_q.frame_index   <= frame_q;
						res_q.frame_column  <= active_q ? rem_q[POS_W-1:0] : '0;
						res_q.frame_row     <= active_q ? quo_q[POS_W-1:0] : '0;
						res_q.is_playing    <= playing_q;
						res_q.callback_hits <= hits_q;
						res_q.active        <= active_q;
						res_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/sprite_sheet_frame_sequencer.sv =====
// Sprite-sheet frame sequencer.
// Channels: "items" takes one action per item (time tick, play, pause) with the
// scaled and unscaled delta times; "results" returns exactly one item per input
// item with the frame, its column and row, the playing flag, the callback hit
// count and the active flag. "cfg" writes one register per handshake (index,
// data) and is always ready; write it only while no item is in flight.
// Steps: a tick on an active sheet runs one multiply, one accumulate, then up
// to MAX_STEPS frame steps, each one loop pass, plus a final compare, then a
// divide setup, a bitwise restoring divide of the 12-bit frame into column and
// row, and an output step. A stop on the last frame skips the final compare.
// Play, pause, idle actions and ticks on an inactive sheet go straight to the
// divide setup. The shared 40-bit subtractor serves both the frame loop and
// the divide, so one item is worked on at a time; the next item is taken once
// the sequencer is back in its idle state after a result is loaded.
// A result waits in the output register while the receiver stalls; the next
// item is accepted meanwhile but its result is held back until the register
// frees. Reset clears the accumulator, frame, playing and callback state and
// loads the register defaults.
module sprite_sheet_frame_sequencer
	import ssfs_pkg::*;
#(
	parameter int MAX_SIDE  = 64,
	parameter int MAX_STEPS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	ssfs_chan_if.sink          cfg,
	ssfs_chan_if.sink          items,
	ssfs_chan_if.source        results
);

	cfg_t     cfg_cur;
	sub_req_t sub_req;
	sub_rsp_t sub_rsp;

	// Register file.
	ssfs_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr       (cfg.data),
		.wr_ready (cfg.ready),
		.cfg      (cfg_cur)
	);

	// Shared subtract and compare unit.
	ssfs_sub_unit u_sub_unit (
		.req (sub_req),
		.rsp (sub_rsp)
	);

	// Sequencer with the animation state.
	ssfs_seq #(
		.MAX_SIDE  (MAX_SIDE),
		.MAX_STEPS (MAX_STEPS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_cur),
		.item_valid (items.valid),
		.item       (items.data),
		.item_ready (items.ready),
		.res_valid  (results.valid),
		.res_ready  (results.ready),
		.res        (results.data),
		.sub_req    (sub_req),
		.sub_rsp    (sub_rsp)
	);

endmodule

// ===== sim/testbench.sv =====
module testbench;
	import ssfs_pkg::*;

	localparam int MAX_SIDE        = 64;
	localparam int MAX_STEPS       = 64;
	localparam int ITEM_TARGET     = 900;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 100;
	localparam int WATCHDOG_LIMIT  = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ssfs_chan_if #(.T(cfg_wr_t))   cfg_if ();
	ssfs_chan_if #(.T(in_item_t))  item_if ();
	ssfs_chan_if #(.T(out_item_t)) result_if ();

	sprite_sheet_frame_sequencer #(
		.MAX_SIDE(MAX_SIDE),
		.MAX_STEPS(MAX_STEPS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if.sink),
		.items(item_if.sink),
		.results(result_if.source)
	);

	// Shadow copy of the register file, at reset values.
	logic [SIDE_W-1:0]  sheet_across   = 7'd1;
	logic [SIDE_W-1:0]  sheet_down     = 7'd1;
	logic [DELTA_W-1:0] sheet_period   = 20'd16667;
	logic [GAIN_W-1:0]  sheet_gain     = 16'd256;
	logic               sheet_loop     = 1'b1;
	logic [FRAME_W-1:0] sheet_cb_frame = '0;
	logic               sheet_cb_every = 1'b0;
	logic               sheet_unscaled = 1'b0;

	// Animation state as the block should hold it.
	logic [ACC_W-1:0]   anim_acc     = '0;
	logic [FRAME_W-1:0] anim_frame   = '0;
	logic               anim_playing = 1'b0;
	logic               cb_fired     = 1'b0;

	out_item_t expected_frames[$];
	int unsigned items_sent = 0;
	int unsigned errors = 0;
	bit sender_idle = 1'b1;
	bit receiver_idle = 1'b1;
	bit hold_results = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Works out the result of one item and moves the animation state on.
	function automatic out_item_t advance_animation(in_item_t it);
		int unsigned across;
		int unsigned down;
		int unsigned total;
		int unsigned steps;
		int unsigned hits;
		int unsigned fi;
		logic [ACC_W-1:0] period;
		logic [ACC_W:0] sum;
		logic [DELTA_W-1:0] dt;
		logic sheet_on;
		out_item_t r;
		across = (sheet_across > MAX_SIDE) ? MAX_SIDE : sheet_across;
		down = (sheet_down > MAX_SIDE) ? MAX_SIDE : sheet_down;
		sheet_on = (across != 0) && (down != 0);
		hits = 0;
		case (action_t'(it.action))
			ACT_PLAY: anim_playing = 1'b1;
			ACT_PAUSE: anim_playing = 1'b0;
			ACT_TICK: begin
				if (sheet_on) begin
					total = across * down;
					if (total > 4096)
						total = 4096;
					period = ACC_W'({sheet_period, 8'h00});
					steps = 0;
					// Time only builds up while playing; the sum saturates.
					if (anim_playing) begin
						dt = sheet_unscaled ? it.unscaled_delta : it.scaled_delta;
						sum = (ACC_W + 1)'(anim_acc) + (ACC_W + 1)'(dt) * (ACC_W + 1)'(sheet_gain);
						anim_acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
					end
					while (anim_playing && anim_acc >= period && steps < MAX_STEPS) begin
						steps++;
						if (anim_frame >= total - 1) begin
							if (sheet_loop) begin
								anim_frame = '0;
							end else begin
								// Holding on the last frame ends playback with no hit test.
								anim_frame = FRAME_W'(total - 1);
								anim_acc = '0;
								anim_playing = 1'b0;
								break;
							end
						end else begin
							anim_frame++;
						end
						anim_acc = anim_acc - period;
						if (anim_frame == sheet_cb_frame && (!cb_fired || sheet_cb_every)) begin
							if (hits < 127)
								hits++;
							cb_fired = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		r = '0;
		r.frame_index = anim_frame;
		fi = 32'(anim_frame);
		if (sheet_on) begin
			r.frame_column = POS_W'(fi % across);
			r.frame_row = POS_W'(fi / across);
		end
		r.is_playing = anim_playing;
		r.callback_hits = HITS_W'(hits);
		r.active = sheet_on;
		return r;
	endfunction

	function automatic in_item_t make_item(action_t act, logic [DELTA_W-1:0] sd,
			logic [DELTA_W-1:0] ud);
		in_item_t it;
		it.action = act;
		it.scaled_delta = sd;
		it.unscaled_delta = ud;
		return it;
	endfunction

	// Deltas mostly land within a few frame periods, with zeros, maximums and noise.
	function automatic logic [DELTA_W-1:0] random_delta();
		longint unsigned reach;
		reach = (longint'(sheet_period) * 768) / ((sheet_gain == 0) ? 1 : sheet_gain);
		if (reach > 20'hFFFFF)
			reach = 20'hFFFFF;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return DELTA_W'($urandom);
			default: return DELTA_W'($urandom_range(0, 32'(reach)));
		endcase
	endfunction

	function automatic in_item_t random_frame_item();
		int unsigned pick;
		action_t act;
		pick = $urandom_range(0, 99);
		if (pick < 78)
			act = ACT_TICK;
		else if (pick < 90)
			act = ACT_PLAY;
		else if (pick < 97)
			act = ACT_PAUSE;
		else
			act = ACT_NONE;
		return make_item(act, random_delta(), random_delta());
	endfunction

	// Sets stray bits above a register's width now and then.
	function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int w);
		if ($urandom_range(0, 5) == 0)
			v = v | CFG_DATA_W'($urandom << w);
		return v;
	endfunction

	function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= cfg_wr_t'{index: idx, data: value};
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		case (idx)
			REG_FRAMES_ACROSS: sheet_across = value[SIDE_W-1:0];
			REG_FRAMES_DOWN: sheet_down = value[SIDE_W-1:0];
			REG_FRAME_PERIOD: sheet_period = value[DELTA_W-1:0];
			REG_SPEED_GAIN: sheet_gain = value[GAIN_W-1:0];
			REG_LOOP_ENABLE: sheet_loop = value[0];
			REG_CALLBACK_FRAME: sheet_cb_frame = value[FRAME_W-1:0];
			REG_CALLBACK_REPEAT: sheet_cb_every = value[0];
			REG_USE_UNSCALED: sheet_unscaled = value[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_sheet(logic [CFG_DATA_W-1:0] across, logic [CFG_DATA_W-1:0] down,
			logic [CFG_DATA_W-1:0] period, logic [CFG_DATA_W-1:0] gain,
			logic [CFG_DATA_W-1:0] loop_on, logic [CFG_DATA_W-1:0] cb_frame,
			logic [CFG_DATA_W-1:0] cb_every, logic [CFG_DATA_W-1:0] unscaled);
		write_reg(REG_FRAMES_ACROSS, across);
		write_reg(REG_FRAMES_DOWN, down);
		write_reg(REG_FRAME_PERIOD, period);
		write_reg(REG_SPEED_GAIN, gain);
		write_reg(REG_LOOP_ENABLE, loop_on);
		write_reg(REG_CALLBACK_FRAME, cb_frame);
		write_reg(REG_CALLBACK_REPEAT, cb_every);
		write_reg(REG_USE_UNSCALED, unscaled);
	endtask

	// Offers one item, after a random gap while sender_idle is set, and records its expected result on acceptance.
	task automatic send_item(in_item_t it);
		int unsigned gap;
		gap = sender_idle ? $urandom_range(0, 17) : 0;
		if (gap != 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.data <= it;
		do @(posedge clk); while (!item_if.ready);
		expected_frames.push_back(advance_animation(it));
		items_sent++;
	endtask

	// Stops offering items and waits until every result is back.
	task automatic wait_idle();
		item_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_frames.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_item(make_item(ACT_TICK, '1, '1));
		send_item(make_item(ACT_NONE, '0, '0));
		send_item(make_item(ACT_PLAY, '0, '0));
		send_item(make_item(ACT_TICK, 20'd16667, '0));
		send_item(make_item(ACT_TICK, 20'd16667, '1));
		send_item(make_item(ACT_PAUSE, '0, '0));
	endtask

	// Oversized sheet, huge carry and zero period all hit the per-tick step limit.
	task automatic test_step_limit();
		wait_idle();
		set_sheet(127, 127, 1, 16'hFFFF, 1, 12'hFFF, 1, 0);
		send_item(make_item(ACT_PLAY, '0, '0));
		send_item(make_item(ACT_TICK, '1, '0));
		send_item(make_item(ACT_TICK, '0, '0));
		wait_idle();
		write_reg(REG_FRAME_PERIOD, 0);
		send_item(make_item(ACT_TICK, '0, '0));
		wait_idle();
		write_reg(REG_CALLBACK_FRAME, 255);
		send_item(make_item(ACT_TICK, '0, '0));
		send_item(make_item(ACT_TICK, '0, '0));
	endtask

	// A zero sheet dimension freezes ticks but play and pause still work.
	task automatic test_zero_dimension();
		wait_idle();
		write_reg(REG_FRAMES_ACROSS, 0);
		send_item(make_item(ACT_TICK, '1, '1));
		send_item(make_item(ACT_PAUSE, '0, '0));
		send_item(make_item(ACT_PLAY, '0, '0));
		wait_idle();
		write_reg(REG_FRAMES_ACROSS, MAX_SIDE);
		write_reg(REG_FRAMES_DOWN, 0);
		send_item(make_item(ACT_TICK, '1, '1));
	endtask

	// Shrinking the sheet leaves the frame past the end; then stop, wrap and repeat hits.
	task automatic test_stop_and_wrap();
		wait_idle();
		set_sheet(4, 2, 100, 256, 0, 7, 0, 1);
		send_item(make_item(ACT_TICK, '0, 20'd100));
		wait_idle();
		write_reg(REG_LOOP_ENABLE, 1);
		write_reg(REG_CALLBACK_REPEAT, 1);
		send_item(make_item(ACT_PLAY, '0, '0));
		send_item(make_item(ACT_TICK, '0, 20'd100));
		send_item(make_item(ACT_TICK, '0, 20'd700));
		send_item(make_item(ACT_TICK, '0, 20'd1600));
		send_item(make_item(ACT_TICK, '1, '0));
	endtask

	// Full gain and delta outrun the step limit until the accumulator pins at its top.
	task automatic test_accumulator_saturation();
		wait_idle();
		set_sheet(MAX_SIDE, MAX_SIDE, 20'hFFFFF, 16'hFFFF, 1,
			CFG_DATA_W'($urandom_range(0, 4095)), 1, 0);
		send_item(make_item(ACT_PLAY, '0, '0));
		repeat (32)
			send_item(make_item(ACT_TICK, DELTA_W'($urandom_range(20'hF0000, 20'hFFFFF)),
				DELTA_W'($urandom)));
	endtask

	// The receiver holds off for a long stretch while items keep coming.
	task automatic test_output_backpressure();
		wait_idle();
		set_sheet(4, 4, 500, 256, 1, 5, 1, 0);
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		hold_results = 1'b1;
		send_item(make_item(ACT_PLAY, '0, '0));
		repeat (12)
			send_item(make_item(ACT_TICK, DELTA_W'($urandom_range(0, 2000)), '0));
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
	endtask

	task automatic randomize_sheet();
		logic [CFG_DATA_W-1:0] across;
		logic [CFG_DATA_W-1:0] down;
		logic [CFG_DATA_W-1:0] period;
		logic [CFG_DATA_W-1:0] gain;
		logic [CFG_DATA_W-1:0] cb_frame;
		int unsigned frames;
		case ($urandom_range(0, 9))
			0: across = 0;
			1: across = MAX_SIDE;
			2: across = CFG_DATA_W'($urandom_range(MAX_SIDE + 1, 127));
			default: across = CFG_DATA_W'($urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 9))
			0: down = 0;
			1: down = MAX_SIDE;
			2: down = CFG_DATA_W'($urandom_range(MAX_SIDE + 1, 127));
			default: down = CFG_DATA_W'($urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 9))
			0: period = 0;
			1: period = 1;
			2: period = 20'hFFFFF;
			3: period = CFG_DATA_W'($urandom);
			default: period = CFG_DATA_W'($urandom_range(50, 3000));
		endcase
		case ($urandom_range(0, 9))
			0: gain = 0;
			1: gain = 16'hFFFF;
			2: gain = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
			default: gain = CFG_DATA_W'($urandom_range(64, 1024));
		endcase
		frames = ((across > MAX_SIDE) ? MAX_SIDE : across) * ((down > MAX_SIDE) ? MAX_SIDE : down);
		if (frames != 0 && $urandom_range(0, 4) != 0)
			cb_frame = CFG_DATA_W'($urandom_range(0, frames - 1));
		else
			cb_frame = CFG_DATA_W'($urandom_range(0, 4095));
		set_sheet(with_junk(across, SIDE_W), with_junk(down, SIDE_W), period,
			with_junk(gain, GAIN_W), with_junk(CFG_DATA_W'($urandom_range(0, 1)), 1),
			with_junk(cb_frame, FRAME_W), with_junk(CFG_DATA_W'($urandom_range(0, 1)), 1),
			with_junk(CFG_DATA_W'($urandom_range(0, 1)), 1));
	endtask

	// Phases of random settings, each opened by a play item.
	task automatic test_random_phases();
		int unsigned count;
		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			randomize_sheet();
			sender_idle = ($urandom_range(0, 3) != 0);
			receiver_idle = ($urandom_range(0, 3) != 0);
			count = $urandom_range(30, 80);
			send_item(make_item(ACT_PLAY, DELTA_W'($urandom), DELTA_W'($urandom)));
			repeat (count)
				send_item(random_frame_item());
		end
	endtask

	// Compares one result item with the oldest expectation.
	task automatic check_frame_result(out_item_t got);
		out_item_t want;
		if (expected_frames.size() == 0) begin
			$error("result item with nothing expected: frame_index %0d", got.frame_index);
			errors++;
			return;
		end
		want = expected_frames.pop_front();
		report_field("frame_index", want.frame_index, got.frame_index);
		report_field("frame_column", want.frame_column, got.frame_column);
		report_field("frame_row", want.frame_row, got.frame_row);
		report_field("is_playing", want.is_playing, got.is_playing);
		report_field("callback_hits", want.callback_hits, got.callback_hits);
		report_field("active", want.active, got.active);
	endtask

	// Result receiver with random stalls and one long hold-off on request.
	initial begin : result_receiver
		int unsigned stall;
		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				result_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end
			stall = receiver_idle ? $urandom_range(0, 17) : 0;
			if (stall != 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
			check_frame_result(result_if.data);
		end
	end

	// Ends the run when no channel has moved an item for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)
					|| (cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin : stimulus
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;
		item_if.valid <= 1'b0;
		item_if.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_step_limit();
		test_zero_dimension();
		test_stop_and_wrap();
		test_accumulator_saturation();
		test_output_backpressure();
		test_random_phases();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ssfs_pkg.sv
rtl/ssfs_chan_if.sv
rtl/ssfs_cfg_regs.sv
rtl/ssfs_sub_unit.sv
rtl/ssfs_seq.sv
rtl/sprite_sheet_frame_sequencer.sv
sim/testbench.sv
